// File: hdl/lora_toa_pkg.sv
// ----------------------------------------------------------------------------
// lora_toa_pkg
// Widths, register indexes, constants and shared divide steps for the
// time-on-air core.
// ----------------------------------------------------------------------------
`default_nettype none

package lora_toa_pkg;

	// field and register widths
	localparam int PL_W      = 8;
	localparam int SF_W      = 4;
	localparam int BW_W      = 19;
	localparam int CR_W      = 4;
	localparam int PRE_W     = 16;
	localparam int MS_W      = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 19;

	// symbol time in microseconds, up to 2^15 * 10^6
	localparam int TSYM_W    = 35;
	// total airtime in microseconds before rounding
	localparam int TOTAL_W   = 53;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SF  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CRC = 3'd5;

	// reset values
	localparam logic [SF_W-1:0]  SF_RST  = 4'd7;
	localparam logic [BW_W-1:0]  BW_RST  = 19'd125000;
	localparam logic [CR_W-1:0]  CR_RST  = 4'd5;
	localparam logic [PRE_W-1:0] PRE_RST = 16'd8;

	// radio constants
	localparam logic [TSYM_W-1:0]  US_PER_S      = 35'd1000000;
	localparam logic [BW_W-1:0]    LDRO_MAX_BW   = 19'd125000;
	localparam logic [SF_W-1:0]    LDRO_MIN_SF   = 4'd11;
	localparam logic [11:0]        FIXED_BITS    = 12'd28;
	localparam logic [11:0]        CRC_BITS      = 12'd16;
	localparam logic [6:0]         HDR_BITS      = 7'd20;
	localparam logic [41:0]        ROUND_UP_US   = 42'd999;
	localparam logic [TOTAL_W-1:0] SAT_LIMIT_US  = 53'd4294967295000;
	localparam logic [7:0]         MS_DIV        = 8'd125;
	localparam logic [5:0]         TSYM_STEPS    = 6'd35;

	typedef struct packed {
		logic       zero;
		logic       sat;
	} toa_flags_t;

	typedef struct packed {
		logic [3:0] rem;
		logic [4:0] quo;
	} sym_div_t;

	typedef struct packed {
		logic [6:0] rem;
		logic [7:0] quo;
	} ms_div_t;

	// five restoring steps of a division by a 4-bit divisor
	function automatic sym_div_t sym_div_5(input logic [3:0] rem, input logic [4:0] bits,
			input logic [3:0] k);
		logic [4:0] t;
		sym_div_t   r;
		r.rem = rem;
		r.quo = '0;
		for (int i = 4; i >= 0; i--) begin
			t = {r.rem, bits[i]};
			if (t >= {1'b0, k}) begin
				r.rem    = 4'(t - {1'b0, k});
				r.quo[i] = 1'b1;
			end else begin
				r.rem = t[3:0];
			end
		end
		return r;
	endfunction

	// eight restoring steps of a division by 125
	function automatic ms_div_t ms_div_8(input logic [6:0] rem, input logic [7:0] bits);
		logic [7:0] t;
		ms_div_t    r;
		r.rem = rem;
		r.quo = '0;
		for (int i = 7; i >= 0; i--) begin
			t = {r.rem, bits[i]};
			if (t >= MS_DIV) begin
				r.rem    = 7'(t - MS_DIV);
				r.quo[i] = 1'b1;
			end else begin
				r.rem = t[6:0];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/lora_time_on_air_core.sv
// ----------------------------------------------------------------------------
// lora_time_on_air_core
// LoRa packet time on air in milliseconds for one payload length per item.
// ----------------------------------------------------------------------------
`default_nettype none

// One payload length goes in per cycle while s_axis_tready is high, and one
// airtime comes out per item through stages s1 to s11 and the output register;
// a stall on the output freezes the whole pipeline and loses nothing. The
// symbol time floor(2^SF * 10^6 / BW) depends only on configuration, so it is
// worked out by a bit-serial divider (one quotient bit per cycle): after reset
// and after every write to the spreading factor or bandwidth register,
// s_axis_tready stays low while that divider runs. Items are also refused in a
// cycle with a configuration write. Airtime saturates at 2^32-1 ms with the
// saturated flag in tuser; a zero bandwidth gives 0 with the flag clear.
module lora_time_on_air_core (
	input  wire                                clk,
	input  wire                                arst_n,
	// input items
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire  [7:0]                         s_axis_tdata,   // [7:0] payload_bytes
	// result items
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	output logic [31:0]                        m_axis_tdata,   // [31:0] toa_ms
	output logic                               m_axis_tuser,   // [0] saturated
	// configuration writes
	input  wire                                cfg_we,
	input  wire  [lora_toa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [lora_toa_pkg::CFG_DAT_W-1:0] cfg_wdata
);
	import lora_toa_pkg::*;

	// configuration registers
	logic [SF_W-1:0]   sf_q;
	logic [BW_W-1:0]   bw_q;
	logic [CR_W-1:0]   cr_q;
	logic [PRE_W-1:0]  pre_q;
	logic              ih_q;
	logic              crc_q;

	// symbol time divider
	logic              start_q;
	logic [5:0]        cnt_q;
	logic [TSYM_W-1:0] sym_us_q;   // dividend shifting out, quotient shifting in
	logic [BW_W-1:0]   rem_q;
	logic [BW_W:0]     trial;

	// pipeline control
	logic              adv;
	logic              accept;
	logic [11:1]       vld_q;

	// derived configuration: low data rate optimisation and the symbol divisor
	logic              ldro;
	logic [SF_W-1:0]   k;

	// stage 1: payload bit count, divided by four and rounded up
	logic [11:0]       pos_bits;
	logic [6:0]        neg_bits;
	logic [11:0]       num;
	logic [11:0]       num_r4;
	logic [9:0]        x4;
	logic [11:0]       num_s1;
	logic [9:0]        dvd_s1;

	// stages 2-3: division by k
	sym_div_t          sd2;
	sym_div_t          sd3;
	logic [3:0]        rem_s2;
	logic [4:0]        quo_hi_s2;
	logic [4:0]        dvd_lo_s2;
	logic [11:0]       num_s2;
	logic [9:0]        q_s3;
	logic [11:0]       num_s3;

	// stage 4: symbol count
	logic [11:0]       qsel;
	logic [15:0]       cr_prod;
	logic [16:0]       sym_cnt_s4;

	// stage 5-6: symbol count times symbol time
	logic [34:0]       pp_lo_s5;
	logic [33:0]       pp_hi_s5;
	logic [TOTAL_W-1:0] total_s6;

	// stage 7: saturation check and divide by 8
	logic [41:0]       rnd_sum;
	toa_flags_t        flg_s7;
	logic [6:0]        ms_rem_s7;
	logic [31:0]       ms_lo_s7;

	// stages 8-11: divide by 125, a byte a stage
	ms_div_t           md8;
	ms_div_t           md9;
	ms_div_t           md10;
	ms_div_t           md11;
	toa_flags_t        flg_s8;
	toa_flags_t        flg_s9;
	toa_flags_t        flg_s10;
	toa_flags_t        flg_s11;
	logic [6:0]        ms_rem_s8;
	logic [6:0]        ms_rem_s9;
	logic [6:0]        ms_rem_s10;
	logic [23:0]       ms_lo_s8;
	logic [15:0]       ms_lo_s9;
	logic [7:0]        ms_lo_s10;
	logic [7:0]        ms_quo_s8;
	logic [15:0]       ms_quo_s9;
	logic [23:0]       ms_quo_s10;
	logic [31:0]       ms_quo_s11;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q  <= SF_RST;
			bw_q  <= BW_RST;
			cr_q  <= CR_RST;
			pre_q <= PRE_RST;
			ih_q  <= 1'b0;
			crc_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SF:  sf_q  <= cfg_wdata[SF_W-1:0];
				REG_BW:  bw_q  <= cfg_wdata[BW_W-1:0];
				REG_CR:  cr_q  <= cfg_wdata[CR_W-1:0];
				REG_PRE: pre_q <= cfg_wdata[PRE_W-1:0];
				REG_IH:  ih_q  <= cfg_wdata[0];
				REG_CRC: crc_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// symbol time divider: restart on reset and on SF or bandwidth writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			cnt_q   <= '0;
		end else begin
			if (cfg_we && (cfg_index == REG_SF || cfg_index == REG_BW)) begin
				start_q <= 1'b1;
			end else if (start_q) begin
				start_q <= 1'b0;
				cnt_q   <= TSYM_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	assign trial = {rem_q, sym_us_q[TSYM_W-1]};

	always_ff @(posedge clk) begin
		if (start_q) begin
			sym_us_q <= US_PER_S << sf_q;
			rem_q    <= '0;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, bw_q}) begin
				rem_q    <= BW_W'(trial - {1'b0, bw_q});
				sym_us_q <= {sym_us_q[TSYM_W-2:0], 1'b1};
			end else begin
				rem_q    <= trial[BW_W-1:0];
				sym_us_q <= {sym_us_q[TSYM_W-2:0], 1'b0};
			end
		end
	end

	// ------------------------------------------------------------------
	// handshake: the whole pipeline moves when the output slot is free
	// ------------------------------------------------------------------
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv && !start_q && (cnt_q == '0) && !cfg_we;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			vld_q         <= {vld_q[10:1], accept};
			m_axis_tvalid <= vld_q[11];
		end
	end

	// ------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------
	assign ldro = (sf_q >= LDRO_MIN_SF) && (bw_q <= LDRO_MAX_BW);
	assign k    = ldro ? sf_q - 4'd2 : sf_q;

	// bits = 8*PL + 28 + 16*CRC - 4*SF - 20*IH, floored at zero
	assign pos_bits = {1'b0, s_axis_tdata, 3'b000} + FIXED_BITS + (crc_q ? CRC_BITS : 12'd0);
	assign neg_bits = {1'b0, sf_q, 2'b00} + (ih_q ? HDR_BITS : 7'd0);
	assign num      = (pos_bits > {5'b0, neg_bits}) ? pos_bits - {5'b0, neg_bits} : 12'd0;
	// ceil(n / 4k) = ceil(ceil(n / 4) / k)
	assign num_r4   = num + 12'd3;
	assign x4       = num_r4[11:2];

	assign sd2 = sym_div_5(4'd0, dvd_s1[9:5], k);
	assign sd3 = sym_div_5(rem_s2, dvd_lo_s2, k);

	// a zero divisor counts as one, so the raw bit count is the quotient
	assign qsel    = (k == '0) ? num_s3 : {2'b00, q_s3};
	assign cr_prod = {4'b0000, qsel} * {12'b0, cr_q};

	// everything not already sized by sat is below 2^42 here
	assign rnd_sum = total_s6[41:0] + ROUND_UP_US;

	assign md8  = ms_div_8(ms_rem_s7, ms_lo_s7[31:24]);
	assign md9  = ms_div_8(ms_rem_s8, ms_lo_s8[23:16]);
	assign md10 = ms_div_8(ms_rem_s9, ms_lo_s9[15:8]);
	assign md11 = ms_div_8(ms_rem_s10, ms_lo_s10);

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: bit count, dividend rounded for the ceiling divide
			num_s1 <= num;
			dvd_s1 <= (k == '0) ? 10'd0 : x4 + {6'b0, k} - 10'd1;

			// s2-s3: quotient by k, five bits a stage
			rem_s2    <= sd2.rem;
			quo_hi_s2 <= sd2.quo;
			dvd_lo_s2 <= dvd_s1[4:0];
			num_s2    <= num_s1;
			q_s3      <= {quo_hi_s2, sd3.quo};
			num_s3    <= num_s2;

			// s4: preamble + 4 + 8 + blocks * CR
			sym_cnt_s4 <= {1'b0, pre_q} + 17'd12 + {1'b0, cr_prod};

			// s5: split product against the 35-bit symbol time
			pp_lo_s5 <= sym_cnt_s4 * sym_us_q[17:0];
			pp_hi_s5 <= sym_cnt_s4 * sym_us_q[34:18];

			// s6: recombine and add the quarter symbol of the preamble
			total_s6 <= {1'b0, pp_hi_s5, 18'b0} + {18'b0, pp_lo_s5}
				+ {20'b0, sym_us_q[34:2]};

			// s7: saturation, round up, divide by eight
			flg_s7.zero <= (bw_q == '0);
			flg_s7.sat  <= (bw_q != '0) && (total_s6 > SAT_LIMIT_US);
			ms_rem_s7   <= rnd_sum[41:35];
			ms_lo_s7    <= rnd_sum[34:3];

			// s8-s11: divide by 125
			flg_s8     <= flg_s7;
			ms_rem_s8  <= md8.rem;
			ms_lo_s8   <= ms_lo_s7[23:0];
			ms_quo_s8  <= md8.quo;

			flg_s9     <= flg_s8;
			ms_rem_s9  <= md9.rem;
			ms_lo_s9   <= ms_lo_s8[15:0];
			ms_quo_s9  <= {ms_quo_s8, md9.quo};

			flg_s10    <= flg_s9;
			ms_rem_s10 <= md10.rem;
			ms_lo_s10  <= ms_lo_s9[7:0];
			ms_quo_s10 <= {ms_quo_s9, md10.quo};

			flg_s11    <= flg_s10;
			ms_quo_s11 <= {ms_quo_s10, md11.quo};

			// output register
			m_axis_tuser <= flg_s11.sat;
			if (flg_s11.zero) begin
				m_axis_tdata <= '0;
			end else if (flg_s11.sat) begin
				m_axis_tdata <= '1;
			end else begin
				m_axis_tdata <= ms_quo_s11;
			end
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_no_accept_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		(start_q || cnt_q != '0) |-> !s_axis_tready)
		else $error("input accepted while symbol time divider busy");

	a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline valid bits moved during output stall");

	a_sat_means_max: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '1))
		else $error("saturated result without maximum airtime");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_q[1])
		else $error("accepted item missing from first stage");

endmodule

`default_nettype wire

// File: tb/tb_lora_time_on_air_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lora_time_on_air_core
// Streams payload lengths into the time-on-air core under a series of radio
// settings and checks every airtime and saturation flag against an
// in-bench calculation of the same packet timing.
// ----------------------------------------------------------------------------

module tb_lora_time_on_air_core;

	import lora_toa_pkg::*;

	// radio timing constants
	localparam longint unsigned US_IN_S     = 64'd1000000;
	localparam int unsigned     LDRO_BW_MAX = 125000;
	localparam int              PAY_FIXED   = 28;
	localparam int              PAY_CRC     = 16;
	localparam int              PAY_HDR     = 20;
	localparam longint unsigned MS_ROUND    = 64'd999;

	localparam int RESET_CYCLES = 6;
	// long output hold-off, well past the pipeline depth
	localparam int HOLD_CYCLES  = 300;
	// settle time after the last result before a register write or the end
	localparam int SETTLE       = 40;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 125;

	typedef struct {
		logic [31:0] ms;
		logic        sat;
	} airtime_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;   // [7:0] payload_bytes
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;        // [31:0] toa_ms
	logic                 m_axis_tuser;        // [0] saturated
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	// bench copy of the radio settings, tracks every register write
	logic [SF_W-1:0]  sf_set  = SF_RST;
	logic [BW_W-1:0]  bw_set  = BW_RST;
	logic [CR_W-1:0]  cr_set  = CR_RST;
	logic [PRE_W-1:0] pre_set = PRE_RST;
	logic             ih_set  = 1'b0;
	logic             crc_set = 1'b1;

	logic [7:0] length_q[$];     // payload lengths waiting to be offered
	airtime_t   airtime_q[$];    // airtimes owed by the core, oldest first

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_reqs      = 0;
	int holds_served   = 0;
	int hold_left      = 0;
	int errors         = 0;

	lora_time_on_air_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #4 clk = ~clk;

	// packet airtime for one payload length under the current settings
	function automatic airtime_t airtime_of(input logic [7:0] pl);
		longint unsigned t_sym, t_pre, n_pay, pkt_us, ms;
		int              num, den;
		logic            ldro;
		airtime_t        r;
		r.ms  = '0;
		r.sat = 1'b0;
		// zero bandwidth short-cuts to a zero airtime
		if (bw_set == 0)
			return r;
		ldro  = (sf_set >= 11) && (bw_set <= LDRO_BW_MAX);
		t_sym = ((64'd1 << sf_set) * US_IN_S) / bw_set;
		t_pre = (longint'(pre_set) + 4) * t_sym + t_sym / 4;
		num = 8 * int'(pl) - 4 * int'(sf_set) + PAY_FIXED
			+ (crc_set ? PAY_CRC : 0) - (ih_set ? PAY_HDR : 0);
		if (num < 0)
			num = 0;
		// spreading factor zero leaves no divisor, treated as one
		den = 4 * (int'(sf_set) - (ldro ? 2 : 0));
		if (den <= 0)
			den = 1;
		n_pay  = 8 + longint'((num + den - 1) / den) * cr_set;
		pkt_us = t_pre + n_pay * t_sym;
		ms     = (pkt_us + MS_ROUND) / 1000;
		if (ms > 64'hFFFF_FFFF) begin
			r.ms  = '1;
			r.sat = 1'b1;
		end else begin
			r.ms = ms[31:0];
		end
		return r;
	endfunction

	// input driver: offers queued lengths, records the airtime owed per accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				airtime_q.push_back(airtime_of(s_axis_tdata));
			// slot is free when nothing is offered or the offer was just taken
			if (!s_axis_tvalid || s_axis_tready) begin
				if (length_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= length_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output ready: random stalls, plus long hold-offs counted here on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left     <= 0;
			holds_served  <= 0;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (holds_served != hold_reqs) begin
			m_axis_tready <= 1'b0;
			hold_left     <= HOLD_CYCLES;
			holds_served  <= holds_served + 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result monitor: compare each accepted result with the oldest airtime owed
	always @(posedge clk) begin
		airtime_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (airtime_q.size() == 0) begin
				$display("%t unexpected result: airtime %0d saturated %0d",
					$time, m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = airtime_q.pop_front();
				if (m_axis_tdata !== want.ms) begin
					$display("%t airtime mismatch: expected %0d actual %0d",
						$time, want.ms, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== want.sat) begin
					$display("%t saturated mismatch: expected %0d actual %0d",
						$time, want.sat, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	// one register write, bench copy follows at the same time
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SF:  sf_set  = val[SF_W-1:0];
			REG_BW:  bw_set  = val[BW_W-1:0];
			REG_CR:  cr_set  = val[CR_W-1:0];
			REG_PRE: pre_set = val[PRE_W-1:0];
			REG_IH:  ih_set  = val[0];
			REG_CRC: crc_set = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_radio(input int sf, input int bw, input int cr, input int pre,
			input int ih, input int crc);
		write_reg(REG_SF,  CFG_DAT_W'(sf));
		write_reg(REG_BW,  CFG_DAT_W'(bw));
		write_reg(REG_CR,  CFG_DAT_W'(cr));
		write_reg(REG_PRE, CFG_DAT_W'(pre));
		write_reg(REG_IH,  CFG_DAT_W'(ih));
		write_reg(REG_CRC, CFG_DAT_W'(crc));
	endtask

	// sender holds back until every owed result is in, then lets the pipe settle
	task automatic drain;
		while (length_q.size() != 0 || s_axis_tvalid || airtime_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
			default: begin send_idle_pct = 18; recv_stall_pct = 18; end
		endcase
	endtask

	initial begin
		int sf, bw, cr, pre;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		set_idling(0);

		// reset settings, length extremes and alternating bit patterns
		length_q = '{8'd0, 8'd255, 8'd1, 8'd127, 8'd128, 8'h55, 8'hAA};
		drain();

		// overflow: huge symbols and the longest preamble
		set_radio(15, 1, 8, 65535, 0, 1);
		length_q = '{8'd0, 8'd255};
		drain();

		// zero bandwidth
		write_reg(REG_BW, '0);
		length_q = '{8'd0, 8'd255};
		drain();

		// spreading factor zero, coding rate zero, implicit header, no crc
		set_radio(0, 524287, 0, 0, 1, 0);
		length_q = '{8'd0, 8'd255, 8'd3};
		drain();

		// low data rate optimisation on at its bandwidth edge
		set_radio(12, 125000, 15, 0, 1, 0);
		length_q = '{8'd0, 8'd1, 8'd255};
		drain();

		// just above the edge, optimisation off
		set_radio(11, 125001, 7, 12, 0, 1);
		length_q = '{8'd0, 8'd255};
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			sf = ($urandom_range(9) < 8) ? $urandom_range(12, 5) : $urandom_range(15, 0);
			case ($urandom_range(7))
				0: bw = 125000;
				1: bw = 250000;
				2: bw = 500000;
				3: bw = 7800 + $urandom_range(3) * 2600;
				4, 5: bw = $urandom_range(500000, 1);
				6: bw = $urandom_range(524287, 1);
				default: bw = $urandom_range(2000, 1);
			endcase
			cr  = ($urandom_range(4) != 0) ? $urandom_range(8, 5) : $urandom_range(15, 0);
			pre = ($urandom_range(9) < 7) ? $urandom_range(64, 0) : $urandom_range(65535, 0);
			set_radio(sf, bw, cr, pre, $urandom_range(1), $urandom_range(1));
			set_idling(ph % 4);
			// long output hold-off while the sender keeps offering
			if (ph == 0 || ph == 4)
				hold_reqs++;
			for (int i = 0; i < PHASE_ITEMS; i++)
				length_q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(1) * 255)
					: 8'($urandom_range(255)));
			drain();
		end

		if (airtime_q.size() != 0)
			$display("%t %0d results never arrived", $time, airtime_q.size());
		if (errors == 0 && airtime_q.size() == 0)
			$display("[lora_time_on_air_core] OK");
		else
			$display("[lora_time_on_air_core] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("[lora_time_on_air_core] ERROR");
		$finish;
	end

endmodule
